// File: sv/assert_macros.svh
// Concurrent assertion helpers; the enclosing module provides clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/mrr_pkg.sv
package mrr_pkg;

   localparam logic [8:0]  COUNT_MAX         = 9'd511;
   localparam logic [15:0] CRC_INIT          = 16'hFFFF;
   localparam logic [15:0] CRC_POLY          = 16'hA001;
   localparam logic [8:0]  LEN_EXCEPTION     = 9'd5;
   localparam logic [8:0]  LEN_WRITE         = 9'd8;
   localparam logic [8:0]  LEN_READ_OVERHEAD = 9'd5;
   localparam logic [8:0]  LEN_MAX           = 9'd260;

   localparam logic [8:0]  POS_UNIT_ID       = 9'd1;
   localparam logic [8:0]  POS_FUNC_CODE     = 9'd2;
   localparam logic [8:0]  POS_BYTE_COUNT    = 9'd3;

   localparam logic [7:0]  FC_READ_COILS      = 8'd1;
   localparam logic [7:0]  FC_READ_DISCRETE   = 8'd2;
   localparam logic [7:0]  FC_READ_HOLDING    = 8'd3;
   localparam logic [7:0]  FC_READ_INPUT      = 8'd4;
   localparam logic [7:0]  FC_WRITE_COIL      = 8'd5;
   localparam logic [7:0]  FC_WRITE_REGISTER  = 8'd6;
   localparam logic [7:0]  FC_WRITE_COILS     = 8'd15;
   localparam logic [7:0]  FC_WRITE_REGISTERS = 8'd16;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       first_byte;
   } req_beat_type;

   typedef struct packed {
      logic [8:0] bytes_seen;
      logic [8:0] expected_length;
      logic       frame_done;
      logic       crc_ok;
      logic [7:0] unit_id;
      logic [7:0] function_code;
      logic       overrun;
   } rsp_beat_type;

   function automatic logic [15:0] crc_take(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) c = (c >> 1) ^ CRC_POLY;
         else      c = c >> 1;
      end
      return c;
   endfunction

   function automatic logic is_read_code(input logic [7:0] fc);
      return (fc == FC_READ_COILS) || (fc == FC_READ_DISCRETE) ||
             (fc == FC_READ_HOLDING) || (fc == FC_READ_INPUT);
   endfunction

   function automatic logic is_write_code(input logic [7:0] fc);
      return (fc == FC_WRITE_COIL) || (fc == FC_WRITE_REGISTER) ||
             (fc == FC_WRITE_COILS) || (fc == FC_WRITE_REGISTERS);
   endfunction

endpackage

// File: sv/mrr_req_if.sv
interface mrr_req_if;
   import mrr_pkg::*;

   logic         valid;
   logic         ready;
   req_beat_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/mrr_rsp_if.sv
interface mrr_rsp_if;
   import mrr_pkg::*;

   logic         valid;
   logic         ready;
   rsp_beat_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/modbus_rtu_response_receiver_unit.sv
// Modbus RTU response receiver: one received byte per beat in, one status beat out per byte.
// A byte is accepted every cycle unless rsp ready stalls; on its way to a result beat it passes
// the input register, then the result register that is written together with the frame state:
// count, CRC-16, unit id, function code, predicted length. The byte-wide CRC update and the
// length check sit in the same stage. req ready follows rsp ready combinationally while both
// registers are full. A beat with first_byte set restarts the frame; after the predicted length
// further bytes flag overrun, and with an unknown length no frame completes.
`include "assert_macros.svh"

module modbus_rtu_response_receiver_unit (
   input  logic      clock,
   input  logic      reset,
   mrr_req_if.sink   req_chan,
   mrr_rsp_if.source rsp_chan
);
   import mrr_pkg::*;

   logic         s1_valid;
   logic         s1_take;
   req_beat_type s1_beat;
   logic         rsp_valid;
   rsp_beat_type rsp_beat;
   logic         req_accept;

   mrr_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .s1_take  (s1_take),
      .s1_valid (s1_valid),
      .s1_beat  (s1_beat)
   );

   mrr_frame_tracker u_tracker (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1_beat  (s1_beat),
      .s1_take  (s1_take),
      .rsp_chan (rsp_chan)
   );

   assign rsp_valid  = rsp_chan.valid;
   assign rsp_beat   = rsp_chan.payload;
   assign req_accept = req_chan.valid && req_chan.ready;

   `ASSERT_IMPLY(a_crc_needs_done, rsp_valid && rsp_beat.crc_ok, rsp_beat.frame_done, "crc_ok without frame_done")
   `ASSERT_IMPLY(a_done_not_over, rsp_valid && rsp_beat.frame_done, !rsp_beat.overrun, "frame_done with overrun")
   `ASSERT_IMPLY(a_done_at_length, rsp_valid && rsp_beat.frame_done, (rsp_beat.bytes_seen == rsp_beat.expected_length) && (rsp_beat.expected_length != 9'd0), "frame_done off length")
   `ASSERT_IMPLY(a_length_range, rsp_valid, rsp_beat.expected_length <= LEN_MAX, "expected_length too large")
   `ASSERT_NEXT(a_accept_loads, req_accept, s1_valid, "accepted beat lost")
endmodule

// File: sv/mrr_in_stage.sv
module mrr_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   mrr_req_if.sink               req_chan,
   input  logic                  s1_take,
   output logic                  s1_valid,
   output mrr_pkg::req_beat_type s1_beat
);
   import mrr_pkg::*;

   logic         valid_ff, valid_in;
   req_beat_type beat_ff;
   logic         accept;

   // Holds a beat until the tracker takes it; refills in the same cycle.
   assign req_chan.ready = !valid_ff || s1_take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept)       valid_in = 1'b1;
      else if (s1_take) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) beat_ff <= req_chan.payload;
   end

   assign s1_valid = valid_ff;
   assign s1_beat  = beat_ff;
endmodule

// File: sv/mrr_frame_tracker.sv
module mrr_frame_tracker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  s1_valid,
   input  mrr_pkg::req_beat_type s1_beat,
   output logic                  s1_take,
   mrr_rsp_if.source             rsp_chan
);
   import mrr_pkg::*;

   logic [8:0]   count_ff, count_in;
   logic [15:0]  crc_ff, crc_in;
   logic [7:0]   uid_ff, uid_in;
   logic [7:0]   fc_ff, fc_in;
   logic [8:0]   plen_ff, plen_in;
   logic         comp_ff, comp_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_beat_type rsp_ff, rsp_in;

   logic [8:0]   cnt_cur;
   logic [15:0]  crc_cur;
   logic [7:0]   uid_cur, fc_cur;
   logic [8:0]   plen_cur;
   logic         comp_cur;
   logic         sat;
   logic         done, over;
   logic [7:0]   b;

   assign s1_take = s1_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign b       = s1_beat.rx_byte;

   always_comb begin
      // a start beat sees the cleared state
      if (s1_beat.first_byte) begin
         cnt_cur  = '0;
         crc_cur  = CRC_INIT;
         uid_cur  = '0;
         fc_cur   = '0;
         plen_cur = '0;
         comp_cur = 1'b0;
      end else begin
         cnt_cur  = count_ff;
         crc_cur  = crc_ff;
         uid_cur  = uid_ff;
         fc_cur   = fc_ff;
         plen_cur = plen_ff;
         comp_cur = comp_ff;
      end

      sat      = (cnt_cur == COUNT_MAX);
      count_in = sat ? cnt_cur : cnt_cur + 9'd1;
      crc_in   = crc_take(crc_cur, b);
      uid_in   = uid_cur;
      fc_in    = fc_cur;
      plen_in  = plen_cur;
      comp_in  = comp_cur;
      done     = 1'b0;
      over     = 1'b0;

      if (comp_cur) begin
         over = 1'b1;
      end else if (!sat) begin
         if (count_in == POS_UNIT_ID) begin
            uid_in = b;
         end else if (count_in == POS_FUNC_CODE) begin
            fc_in = b;
            if (b[7])                plen_in = LEN_EXCEPTION;
            else if (is_write_code(b)) plen_in = LEN_WRITE;
            else                     plen_in = '0;
         end else if (count_in == POS_BYTE_COUNT && !fc_cur[7] && is_read_code(fc_cur)) begin
            plen_in = LEN_READ_OVERHEAD + {1'b0, b};
         end
         if (plen_in != '0 && count_in == plen_in) begin
            done    = 1'b1;
            comp_in = 1'b1;
         end
      end

      rsp_in.bytes_seen      = count_in;
      rsp_in.expected_length = plen_in;
      rsp_in.frame_done      = done;
      rsp_in.crc_ok          = done && (crc_in == 16'h0000);
      rsp_in.unit_id         = uid_in;
      rsp_in.function_code   = fc_in;
      rsp_in.overrun         = over;

      rsp_valid_in = rsp_valid_ff;
      if (s1_take)             rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         crc_ff       <= CRC_INIT;
         uid_ff       <= '0;
         fc_ff        <= '0;
         plen_ff      <= '0;
         comp_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (s1_take) begin
            count_ff <= count_in;
            crc_ff   <= crc_in;
            uid_ff   <= uid_in;
            fc_ff    <= fc_in;
            plen_ff  <= plen_in;
            comp_ff  <= comp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;
endmodule
